>>> rtl/core/swmr_pkg.sv
package swmr_pkg;

  localparam int WINDOW_MAX_DEF = 1024;
  localparam int VAL_W          = 31;
  localparam int CFG_W          = 11;
  localparam int TDATA_W        = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input transfer into the item registers
    logic front;   // drop expired entries at deque heads
    logic back;    // drop dominated entries at deque tails
    logic push;    // append the item to both deques
    logic eval;    // fold the window range into the best so far
    logic finish;  // hand the best range to the output, clear the sequence
  } swmr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic front_pend;
    logic back_pend;
    logic last;
    logic out_busy;
  } swmr_stat_t;

endpackage

>>> rtl/core/sliding_window_max_range_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata[30:0] income, tlast last_item
// m_axis    out        tdata[30:0] max_difference, one transfer per closing item
// cfg       in         cfg_data window_size
//
// Before its push an item runs drop steps, each deque dropping one entry a cycle:
// the larger head-expiry count of the two deques plus the larger tail count.
// A result is registered at the closing item's push, then taken into an output register; a
// later closing item holds in its last cycle, input stalled, until that is free.
// Reset (rst, synchronous) sets window_size to 1 and empties both deques at once.
module sliding_window_max_range_top
  import swmr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [30:0] income
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [30:0] max_difference
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  swmr_cmd_t        cmd;
  swmr_stat_t       stat;
  logic [VAL_W-1:0] out_data;

  swmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swmr_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_val    (s_axis_tdata[VAL_W-1:0]),
    .in_last   (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = TDATA_W'(out_data);

endmodule

>>> rtl/core/swmr_deque.sv
module swmr_deque
  import swmr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 pop_front,
  input  logic                                 pop_back,
  input  logic                                 push,
  input  logic [VAL_W-1:0]                     wr_val,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]      wr_pos,
  output logic [VAL_W-1:0]                     head_val,
  output logic [$clog2(WINDOW_MAX+1)-1:0]      head_pos,
  output logic [VAL_W-1:0]                     tail_val,
  output logic                                 empty
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int EW = VAL_W + KW;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_MAX - 1);

  logic [EW-1:0] mem [WINDOW_MAX];
  logic [EW-1:0] rd_head;
  logic [EW-1:0] rd_tail;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [KW-1:0] count, count_next;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : AW'(i - 1'b1);
  endfunction

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (clear) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else if (pop_front) begin
      head_next  = ring_inc(head);
      count_next = KW'(count - 1'b1);
    end else if (pop_back) begin
      tail_next  = ring_dec(tail);
      count_next = KW'(count - 1'b1);
    end else if (push) begin
      tail_next  = ring_inc(tail);
      count_next = KW'(count + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // reads follow the next pointers, so the read data matches the updated pointers;
  // the entry written by a push reads stale until it is read again
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= {wr_pos, wr_val};
    end
    rd_head <= mem[head_next];
    rd_tail <= mem[ring_dec(tail_next)];
  end

  assign head_val = rd_head[VAL_W-1:0];
  assign head_pos = rd_head[EW-1:VAL_W];
  assign tail_val = rd_tail[VAL_W-1:0];
  assign empty    = (count == '0);

endmodule

>>> rtl/core/swmr_datapath.sv
module swmr_datapath
  import swmr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  swmr_cmd_t          cmd,
  output swmr_stat_t         stat,
  input  logic [VAL_W-1:0]   in_val,
  input  logic               in_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VAL_W-1:0]   out_data
);

  localparam int KW = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0] window_size;
  logic [KW-1:0]    k;
  logic [KW-1:0]    k_in;
  logic [31:0]      ws32;
  logic [VAL_W-1:0] v;
  logic             last;
  logic [KW-1:0]    pos;
  logic [KW-1:0]    fill;
  logic [VAL_W-1:0] best, best_next;
  logic [VAL_W-1:0] diff;
  logic             full;

  logic [VAL_W-1:0] max_head_val, min_head_val, max_tail_val, min_tail_val;
  logic [KW-1:0]    max_head_pos, min_head_pos;
  logic             max_empty, min_empty;
  logic             max_expired, min_expired, max_dom, min_dom;
  logic [KW-1:0]    max_age, min_age;
  logic [VAL_W-1:0] hi, lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    ws32 = 32'(window_size);
    if (ws32 == 32'd0) begin
      k_in = KW'(1);
    end else if (ws32 > 32'(WINDOW_MAX)) begin
      k_in = KW'(WINDOW_MAX);
    end else begin
      k_in = KW'(ws32);
    end
  end

  // age is exact modulo 2^KW, as no live entry is older than WINDOW_MAX
  assign max_age     = KW'(pos - max_head_pos);
  assign min_age     = KW'(pos - min_head_pos);
  assign max_expired = !max_empty && (max_age >= k);
  assign min_expired = !min_empty && (min_age >= k);
  assign max_dom     = !max_empty && (max_tail_val <= v);
  assign min_dom     = !min_empty && (min_tail_val >= v);

  swmr_deque #(.WINDOW_MAX(WINDOW_MAX)) u_max (
    .clk       (clk),
    .rst       (rst),
    .clear     (cmd.finish),
    .pop_front (cmd.front && max_expired),
    .pop_back  (cmd.back && max_dom),
    .push      (cmd.push),
    .wr_val    (v),
    .wr_pos    (pos),
    .head_val  (max_head_val),
    .head_pos  (max_head_pos),
    .tail_val  (max_tail_val),
    .empty     (max_empty)
  );

  swmr_deque #(.WINDOW_MAX(WINDOW_MAX)) u_min (
    .clk       (clk),
    .rst       (rst),
    .clear     (cmd.finish),
    .pop_front (cmd.front && min_expired),
    .pop_back  (cmd.back && min_dom),
    .push      (cmd.push),
    .wr_val    (v),
    .wr_pos    (pos),
    .head_val  (min_head_val),
    .head_pos  (min_head_pos),
    .tail_val  (min_tail_val),
    .empty     (min_empty)
  );

  // an empty deque gets the new item as its head
  assign hi = max_empty ? v : max_head_val;
  assign lo = min_empty ? v : min_head_val;

  assign best_next = (full && (diff > best)) ? diff : best;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v    <= in_val;
      last <= in_last;
      k    <= k_in;
    end
    if (cmd.push) begin
      diff <= (hi >= lo) ? VAL_W'(hi - lo) : '0;
      full <= (fill >= KW'(k - 1'b1));
    end
    if (cmd.finish) begin
      out_data <= best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      fill      <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        pos  <= '0;
        fill <= '0;
        best <= '0;
      end else begin
        if (cmd.push) begin
          pos <= KW'(pos + 1'b1);
          if (fill != KW'(WINDOW_MAX)) begin
            fill <= KW'(fill + 1'b1);
          end
        end
        if (cmd.eval) begin
          best <= best_next;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.front_pend = max_expired || min_expired;
  assign stat.back_pend  = max_dom || min_dom;
  assign stat.last       = last;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

>>> rtl/core/swmr_ctrl.sv
module swmr_ctrl
  import swmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  swmr_stat_t stat,
  output swmr_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0] state, state_next;
  logic       eval_ok;

  // a closing item waits until the output register is free
  assign eval_ok = !(stat.last && stat.out_busy);

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat.front_pend) begin
          cmd.front = 1'b1;
        end else if (stat.back_pend) begin
          cmd.back = 1'b1;
        end else begin
          cmd.push   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_ok) begin
          cmd.eval   = !stat.last;
          cmd.finish = stat.last;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_WORK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> tb/sliding_window_max_range_top_test.sv
module sliding_window_max_range_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swmr_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  localparam int QUIET_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 400;
  // one item may drop up to a full deque at each end, one entry per cycle
  localparam int SETTLE_CYCLES = 2 * WINDOW_MAX_DEF + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SQUEEZE_PHASE = 3;
  localparam int PLAN_LEN      = 11;
  localparam logic [CFG_W-1:0] PLAN [PLAN_LEN] = '{
    11'd2, 11'd3, 11'd5, 11'd1, 11'd8, 11'd0, 11'd17, 11'd1024, 11'd64, 11'd1500, 11'd4
  };
  localparam logic [VAL_W-1:0] VAL_TOP = {VAL_W{1'b1}};

  typedef enum int {MIX_ANY, MIX_NARROW, MIX_RISING, MIX_FALLING, MIX_EXTREME} income_mix_t;

  // Tracks the window extremes per sequence with two monotonic deques and
  // holds the widest ranges still owed by the block.
  class range_tracker;
    localparam int unsigned SLOTS = WINDOW_MAX_DEF;
    localparam int SIDE_MAX = 0;
    localparam int SIDE_MIN = 1;

    logic [VAL_W-1:0] kept_val [2][SLOTS];
    logic [31:0]      kept_pos [2][SLOTS];
    int unsigned      head [2];
    int unsigned      tail [2];
    int unsigned      fill [2];
    logic [CFG_W-1:0] window;
    logic [31:0]      next_pos;
    bit               wrapped;
    logic [VAL_W-1:0] widest;
    logic [VAL_W-1:0] due_ranges [$];
    int               errors;
    int               checked;

    function new();
      window  = CFG_W'(1);
      errors  = 0;
      checked = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      for (int s = 0; s < 2; s++) begin
        head[s] = 0;
        tail[s] = 0;
        fill[s] = 0;
      end
      next_pos = '0;
      wrapped  = 1'b0;
      widest   = '0;
    endfunction

    function int unsigned slot_before(int unsigned i);
      return (i + SLOTS - 1) % SLOTS;
    endfunction

    function void slide(int side, logic [VAL_W-1:0] v, logic [31:0] pos, logic [31:0] span);
      // expired entries leave from the head; distance is taken modulo 2^32
      while (fill[side] > 0 && (pos - kept_pos[side][head[side]]) >= span) begin
        head[side] = (head[side] + 1) % SLOTS;
        fill[side]--;
      end
      while (fill[side] > 0 &&
             ((side == SIDE_MAX) ? (kept_val[side][slot_before(tail[side])] <= v)
                                 : (kept_val[side][slot_before(tail[side])] >= v))) begin
        tail[side] = slot_before(tail[side]);
        fill[side]--;
      end
      if (fill[side] >= SLOTS) begin
        head[side] = (head[side] + 1) % SLOTS;
        fill[side]--;
      end
      kept_val[side][tail[side]] = v;
      kept_pos[side][tail[side]] = pos;
      tail[side] = (tail[side] + 1) % SLOTS;
      fill[side]++;
    endfunction

    function void note_income(logic [VAL_W-1:0] v, logic closes);
      logic [31:0]      span;
      logic [31:0]      pos;
      logic [VAL_W-1:0] hi;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] diff;
      span = 32'(window);
      if (span == 0) span = 1;
      if (span > SLOTS) span = SLOTS;
      pos = next_pos;
      slide(SIDE_MAX, v, pos, span);
      slide(SIDE_MIN, v, pos, span);
      if (wrapped || pos >= span - 1) begin
        hi   = kept_val[SIDE_MAX][head[SIDE_MAX]];
        lo   = kept_val[SIDE_MIN][head[SIDE_MIN]];
        diff = (hi >= lo) ? hi - lo : '0;
        if (diff > widest) widest = diff;
      end
      next_pos = pos + 1;
      if (next_pos == 0) wrapped = 1'b1;
      if (closes) begin
        due_ranges = {due_ranges, widest};
        clear_sequence();
      end
    endfunction

    function void check_range(logic [TDATA_W-1:0] data);
      logic [VAL_W-1:0] want;
      if (due_ranges.size() == 0) begin
        $display("%0t: max_difference %0d with none expected", $time, data[VAL_W-1:0]);
        errors++;
      end else begin
        want = due_ranges.pop_front();
        checked++;
        if (data[VAL_W-1:0] !== want) begin
          $display("%0t: max_difference mismatch: expected %0d, actual %0d",
                   $time, want, data[VAL_W-1:0]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return due_ranges.size();
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;  // [30:0] income
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [30:0] max_difference
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data      = '0;

  range_tracker ranges;
  int items_sent       = 0;
  int sequences        = 0;
  int settings_written = 0;
  int gap_pct          = 0;
  bit quiet            = 1'b0;
  int hold_requests    = 0;
  int holds_served     = 0;
  int hold_left        = 0;
  int stall_left       = 0;
  int calm_left        = 0;
  int cycle_count      = 0;

  sliding_window_max_range_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Everything moves on the rising edge, so the falling edge sees exactly
  // what the next rising edge will transfer.
  always @(negedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ranges.window = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        ranges.note_income(s_axis_tdata[VAL_W-1:0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) ranges.check_range(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, ranges.pending());
      $display("sliding_window_max_range_top test failed");
      $finish;
    end
  end

  // result side: random stall bursts, calm stretches and the odd long hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= hold_requests;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (quiet || calm_left > 0) begin
      if (calm_left > 0) calm_left <= calm_left - 1;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 12) begin
      stall_left    <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 3) calm_left <= $urandom_range(30, 120);
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [VAL_W-1:0] v, input logic closes);
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(v);
    s_axis_tlast  <= closes;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (closes) sequences++;
    if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet <= 1'b1;
  endtask

  task automatic send_sequence(input int len, input income_mix_t mix, input logic closes);
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mix)
        MIX_NARROW:  v = VAL_W'(32'd1000 + $urandom_range(0, 7));
        MIX_RISING:  v = v + VAL_W'($urandom_range(0, 3));
        MIX_FALLING: v = v - VAL_W'($urandom_range(0, 3));
        MIX_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = VAL_TOP;
            2:       v = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
            default: v = ~(VAL_W'(1) << $urandom_range(0, VAL_W - 1));
          endcase
        end
        default:     v = VAL_W'($urandom);
      endcase
      send_item(v, closes && i == len - 1);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (ranges.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] setting);
    wait_drained();
    // an item that closes nothing may still be working through its deques
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic run_directed();
    send_item(VAL_TOP, 1'b1);
    send_item('0, 1'b0);
    send_item(VAL_TOP, 1'b1);
    write_window(11'd2);
    send_item('0, 1'b0);
    send_item(VAL_TOP, 1'b0);
    send_item('0, 1'b1);
    send_item(VAL_W'(5), 1'b1);              // shorter than the window
    write_window(11'd0);                     // zero acts as a window of one
    send_item(VAL_W'(3), 1'b0);
    send_item(VAL_W'(9), 1'b1);
    write_window(11'd2047);                  // saturates at the deque depth
    send_item(VAL_W'(1), 1'b0);
    send_item(VAL_TOP, 1'b0);
    send_item('0, 1'b1);
    write_window(11'd3);
    for (int i = 0; i < 4; i++) send_item(VAL_W'(7), i == 3);
    send_item(VAL_W'(32'h2AAA_AAAA), 1'b0);
    send_item(VAL_W'(32'h5555_5555), 1'b0);
    send_item(VAL_W'(1), 1'b0);
    send_item(VAL_W'(9), 1'b0);
    write_window(11'd2);                     // window shrinks with a sequence open
    send_item(VAL_W'(20), 1'b1);
    send_item(VAL_W'(6), 1'b0);
    send_item(VAL_W'(2), 1'b0);
    write_window(11'd4);                     // and grows with one open
    send_item(VAL_W'(11), 1'b0);
    send_item(VAL_W'(3), 1'b1);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] setting, input bit squeeze);
    int span;
    int longest;
    write_window(setting);
    span = (setting == 0) ? 1 : (setting > WINDOW_MAX_DEF ? WINDOW_MAX_DEF : setting);
    if (squeeze) begin
      // stall the result side while closing items keep coming, then let it all drain
      gap_pct = 0;
      hold_requests <= hold_requests + 1;
      repeat (40) send_sequence($urandom_range(1, 2), MIX_ANY, 1'b1);
      wait_drained();
    end
    gap_pct = $urandom_range(0, 2) * 15;
    if (span >= 512) begin
      if (setting == WINDOW_MAX_DEF)
        send_sequence(span + $urandom_range(0, 20), income_mix_t'($urandom_range(0, 4)), 1'b1);
      repeat (3)
        send_sequence($urandom_range(1, 30), income_mix_t'($urandom_range(0, 4)), 1'b1);
    end else begin
      longest = span * 3 + 8;
      if (longest > 60) longest = 60;
      repeat ($urandom_range(4, 10))
        send_sequence($urandom_range(1, longest), income_mix_t'($urandom_range(0, 4)), 1'b1);
      if ($urandom_range(0, 99) < 20)
        send_sequence($urandom_range(1, span + 2), income_mix_t'($urandom_range(0, 4)), 1'b0);
    end
  endtask

  initial begin
    ranges = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PLAN_LEN; p++) run_phase(PLAN[p], p == SQUEEZE_PHASE);
    while (items_sent < ITEM_TARGET) run_phase(CFG_W'($urandom_range(1, 40)), 1'b0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ranges.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, ranges.pending());
      ranges.errors++;
    end
    $display("Run: %0d income values, %0d closed sequences, %0d window writes",
             items_sent, sequences, settings_written);
    $display("Ranges compared: %0d, mismatches: %0d", ranges.checked, ranges.errors);
    if (ranges.errors == 0) begin
      $display("sliding_window_max_range_top test passed");
    end else begin
      $display("sliding_window_max_range_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/swmr_pkg.sv
rtl/core/swmr_deque.sv
rtl/core/swmr_datapath.sv
rtl/core/swmr_ctrl.sv
rtl/core/sliding_window_max_range_top.sv
tb/sliding_window_max_range_top_test.sv
